/* sv/sacl_pkg.sv */
package sacl_pkg;

    localparam int ADDR_W    = 32;
    localparam int TAG_W     = 24;
    localparam int CNT_W     = 32;
    localparam int SET_OUT_W = 4;
    localparam int WAY_OUT_W = 2;
    localparam int OFF_OUT_W = 4;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // One cache line's bookkeeping as kept in the tag RAM
    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [CNT_W-1:0] stamp;
        logic [CNT_W-1:0] uses;
    } line_t;

    localparam int LINE_W = $bits(line_t);

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        r = (v == CNT_MAX) ? v : v + CNT_W'(1);
        return r;
    endfunction

endpackage

/* sv/set_assoc_cache_lookup.sv */
// Tag and replacement engine of a set-associative cache. Each address transfer
// is split into block offset, set and tag; the set's row (tag, fill stamp and
// use count of every way) is read from a single-port-per-side tag RAM, all ways
// are compared in parallel, and the row is written back with the hit line's use
// count raised or the chosen line refilled. Victim on a full set: oldest fill
// stamp (replacement_mode 0) or fewest uses since fill (replacement_mode 1),
// lowest way on a tie. A lookup reads the set row from RAM, then compares,
// picks a victim and writes back; no new address is taken while a lookup is
// in flight, and it stays in flight while the last result waits on out_stall.
// Valid bits live in flops and clear at reset, so no clearing pass is needed.
// Hit, miss and fill counters saturate at all ones. The user must write
// replacement_mode via cfg_data only while no lookup is in flight; unchecked.
module set_assoc_cache_lookup #(
    parameter int SETS        = 16,
    parameter int WAYS        = 4,
    parameter int OFFSET_BITS = 4,
    parameter int ADDR_BITS   = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_data,

    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [sacl_pkg::ADDR_W-1:0]       address,

    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              hit,
    output logic [sacl_pkg::SET_OUT_W-1:0]    set_index,
    output logic [sacl_pkg::WAY_OUT_W-1:0]    way,
    output logic [sacl_pkg::TAG_W-1:0]        line_tag,
    output logic [sacl_pkg::OFF_OUT_W-1:0]    block_offset,
    output logic [sacl_pkg::CNT_W-1:0]        hit_total,
    output logic [sacl_pkg::CNT_W-1:0]        miss_total
);

    localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int SET_SB = $clog2(SETS + 1) - 1;
    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ROW_W  = WAYS * sacl_pkg::LINE_W;
    localparam int AW     = sacl_pkg::ADDR_W;
    localparam int CW     = sacl_pkg::CNT_W;
    localparam int TW     = sacl_pkg::TAG_W;

    localparam logic [AW-1:0] ADDR_MASK = (ADDR_BITS >= AW) ? {AW{1'b1}} :
        AW'((64'(1) << ADDR_BITS) - 64'(1));
    localparam logic [AW-1:0] OFF_MASK = AW'((64'(1) << OFFSET_BITS) - 64'(1));
    localparam logic [SET_W-1:0] SET_MASK = SET_W'(SETS - 1);

    typedef enum logic [0:0] {
        S_IDLE,
        S_LOOK
    } state_t;

    state_t state_reg;
    logic   mode_reg;

    logic [WAYS-1:0]    valid_reg [SETS];
    logic [CW-1:0]      stamp_reg;
    logic [CW-1:0]      hit_cnt_reg;
    logic [CW-1:0]      miss_cnt_reg;

    logic [SET_W-1:0]   set_reg;
    logic [TW-1:0]      tag_reg;
    logic [sacl_pkg::OFF_OUT_W-1:0] off_reg;

    logic                            out_valid_reg;
    logic                            hit_reg;
    logic [sacl_pkg::SET_OUT_W-1:0]  set_out_reg;
    logic [sacl_pkg::WAY_OUT_W-1:0]  way_reg;
    logic [TW-1:0]                   tag_out_reg;
    logic [sacl_pkg::OFF_OUT_W-1:0]  off_out_reg;
    logic [CW-1:0]                   hit_total_reg;
    logic [CW-1:0]                   miss_total_reg;

    logic [AW-1:0]      addr_m;
    logic [SET_W-1:0]   in_set;
    logic [TW-1:0]      in_tag;
    logic [sacl_pkg::OFF_OUT_W-1:0] in_off;
    logic               in_xfer;
    logic               done;

    logic [ROW_W-1:0]   row_rd;
    logic [ROW_W-1:0]   row_next;
    sacl_pkg::line_t    lines [WAYS];
    logic [CW-1:0]      key [WAYS];
    logic [WAYS-1:0]    cur_valid;
    logic [WAYS-1:0]    hit_vec;
    logic               look_hit;
    logic [WAY_W-1:0]   hit_way;
    logic               free_any;
    logic [WAY_W-1:0]   free_way;
    logic [WAY_W-1:0]   victim;
    logic [WAY_W-1:0]   sel_way;
    sacl_pkg::line_t    line_next;
    logic [CW-1:0]      hit_cnt_next;
    logic [CW-1:0]      miss_cnt_next;

    // address split
    assign addr_m  = address & ADDR_MASK;
    assign in_off  = sacl_pkg::OFF_OUT_W'(addr_m & OFF_MASK);
    assign in_set  = SET_W'(addr_m >> OFFSET_BITS) & SET_MASK;
    assign in_tag  = TW'(addr_m >> (OFFSET_BITS + SET_SB));

    assign in_stall  = (state_reg != S_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign done      = (state_reg == S_LOOK) && (!out_valid_reg || !out_stall);
    assign cfg_ready = 1'b1;

    sacl_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_tag_ram (
        .clk   (clk),
        .we    (done),
        .waddr (set_reg),
        .wdata (row_next),
        .re    (in_xfer),
        .raddr (in_set),
        .rdata (row_rd)
    );

    assign cur_valid = valid_reg[set_reg];

    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            lines[w]   = row_rd[w*sacl_pkg::LINE_W +: sacl_pkg::LINE_W];
            key[w]     = mode_reg ? lines[w].uses : lines[w].stamp;
            hit_vec[w] = cur_valid[w] && (lines[w].tag == tag_reg);
        end
        look_hit = |hit_vec;
        free_any = ~&cur_valid;

        // lowest matching / lowest invalid way
        hit_way  = '0;
        free_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (hit_vec[w])
            begin
                hit_way = WAY_W'(w);
            end
            if (!cur_valid[w])
            begin
                free_way = WAY_W'(w);
            end
        end

        // strict less-than keeps the lowest way on a tie
        victim = '0;
        for (int w = 1; w < WAYS; w++)
        begin
            if (key[w] < key[victim])
            begin
                victim = WAY_W'(w);
            end
        end

        priority if (look_hit)
        begin
            sel_way = hit_way;
        end
        else if (free_any)
        begin
            sel_way = free_way;
        end
        else
        begin
            sel_way = victim;
        end

        if (look_hit)
        begin
            line_next      = lines[hit_way];
            line_next.uses = sacl_pkg::sat_inc(lines[hit_way].uses);
            hit_cnt_next   = sacl_pkg::sat_inc(hit_cnt_reg);
            miss_cnt_next  = miss_cnt_reg;
        end
        else
        begin
            line_next.tag   = tag_reg;
            line_next.stamp = stamp_reg;
            line_next.uses  = '0;
            hit_cnt_next    = hit_cnt_reg;
            miss_cnt_next   = sacl_pkg::sat_inc(miss_cnt_reg);
        end

        for (int w = 0; w < WAYS; w++)
        begin
            row_next[w*sacl_pkg::LINE_W +: sacl_pkg::LINE_W] =
                (WAY_W'(w) == sel_way) ? line_next : lines[w];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            set_reg <= in_set;
            tag_reg <= in_tag;
            off_reg <= in_off;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mode_reg       <= 1'b0;
            stamp_reg      <= '0;
            hit_cnt_reg    <= '0;
            miss_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
            hit_reg        <= 1'b0;
            set_out_reg    <= '0;
            way_reg        <= '0;
            tag_out_reg    <= '0;
            off_out_reg    <= '0;
            hit_total_reg  <= '0;
            miss_total_reg <= '0;
            for (int s = 0; s < SETS; s++)
            begin
                valid_reg[s] <= '0;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                mode_reg <= cfg_data;
            end

            if (done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        state_reg <= S_LOOK;
                    end
                end
                S_LOOK:
                begin
                    if (done)
                    begin
                        state_reg                   <= S_IDLE;
                        valid_reg[set_reg][sel_way] <= 1'b1;
                        hit_cnt_reg                 <= hit_cnt_next;
                        miss_cnt_reg                <= miss_cnt_next;
                        if (!look_hit)
                        begin
                            stamp_reg <= sacl_pkg::sat_inc(stamp_reg);
                        end
                        hit_reg        <= look_hit;
                        set_out_reg    <= sacl_pkg::SET_OUT_W'(set_reg);
                        way_reg        <= sacl_pkg::WAY_OUT_W'(sel_way);
                        tag_out_reg    <= tag_reg;
                        off_out_reg    <= off_reg;
                        hit_total_reg  <= hit_cnt_next;
                        miss_total_reg <= miss_cnt_next;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign hit          = hit_reg;
    assign set_index    = set_out_reg;
    assign way          = way_reg;
    assign line_tag     = tag_out_reg;
    assign block_offset = off_out_reg;
    assign hit_total    = hit_total_reg;
    assign miss_total   = miss_total_reg;

    // a finished lookup bumps exactly one of the hit and miss counters
    assert property (@(posedge clk) disable iff (!rst_n)
        done && (hit_cnt_reg != sacl_pkg::CNT_MAX) && (miss_cnt_reg != sacl_pkg::CNT_MAX)
        |=> ((hit_cnt_reg != $past(hit_cnt_reg)) != (miss_cnt_reg != $past(miss_cnt_reg))))
        else $error("lookup did not count exactly one hit or miss");

    // fill stamp moves only on a miss
    assert property (@(posedge clk) disable iff (!rst_n)
        !(done && !look_hit) |=> $stable(stamp_reg))
        else $error("fill stamp changed without a fill");

    // a miss with a free way never evicts a valid line
    assert property (@(posedge clk) disable iff (!rst_n)
        done && !look_hit && free_any |-> !cur_valid[sel_way])
        else $error("valid line replaced while an invalid way was free");

    // at most one way of a set may hold a given tag
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOOK) |-> $onehot0(hit_vec))
        else $error("tag present in more than one way");

endmodule

/* sv/sacl_ram.sv */
module sacl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
